// ----- hw/rtl/apom_pkg.sv -----
// package for the adapter prefix overlap matcher
// request, outcome, register and cell-operation codes, defaults, cell control struct
// no dependencies
`default_nettype none
package apom_pkg;

	localparam int MAX_ADAPTERS_DEF    = 16;
	localparam int MAX_ADAPTER_LEN_DEF = 64;
	localparam int MAX_READ_LEN_DEF    = 256;

	localparam int PERCENT_SCALE = 100;

	localparam logic [1:0] REQ_CLEAR   = 2'd0;
	localparam logic [1:0] REQ_ADAPTER = 2'd1;
	localparam logic [1:0] REQ_READ    = 2'd2;

	localparam logic [1:0] OUT_NO_MATCH = 2'd0;
	localparam logic [1:0] OUT_MATCH    = 2'd1;
	localparam logic [1:0] OUT_INVALID  = 2'd2;

	localparam logic [1:0] REG_MIN_OVERLAP   = 2'd0;
	localparam logic [1:0] REG_MATCH_PERCENT = 2'd1;
	localparam logic [1:0] REG_QUALITY_FLOOR = 2'd2;

	localparam logic [5:0] MIN_OVERLAP_RST   = 6'd8;
	localparam logic [6:0] MATCH_PERCENT_RST = 7'd80;
	localparam logic [7:0] QUALITY_FLOOR_RST = 8'd48;

	localparam logic [2:0] CELL_HOLD  = 3'd0;
	localparam logic [2:0] CELL_CLEAR = 3'd1;
	localparam logic [2:0] CELL_LOAD  = 3'd2;
	localparam logic [2:0] CELL_RUN   = 3'd3;
	localparam logic [2:0] CELL_EVAL  = 3'd4;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] rbase;
		logic       qlow;
	} cell_ctl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/adapter_prefix_overlap_matcher_top.sv -----
// top level of the adapter prefix overlap matcher
// depends on apom_pkg, apom_ram, apom_cell
//
// channel | dir | handshake        | contents
// s_      | in  | tvalid/tready    | tdata: symbol, quality; tuser: req_type; tlast: last
// m_      | out | tvalid/tready    | tdata: outcome
// apb     | in  | psel/penable     | min_overlap, match_percent, quality_floor
//
// adapter and read bases load in one cycle each while s_tready is high
// a read's last base starts a search over the adapters in order; for each one the length
// is checked, the adapter is loaded into the cell row, the read streamed past it and the
// scores shifted out; a hit, a short adapter (invalid) or the table end ends the search
// s_tready is low from a read's last base until its outcome enters the output slot
// reset clears counts, registers and the output slot; memories are not cleared
`default_nettype none
module adapter_prefix_overlap_matcher_top #(
	parameter int MAX_ADAPTERS    = apom_pkg::MAX_ADAPTERS_DEF,
	parameter int MAX_ADAPTER_LEN = apom_pkg::MAX_ADAPTER_LEN_DEF,
	parameter int MAX_READ_LEN    = apom_pkg::MAX_READ_LEN_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // symbol[7:0], quality[15:8]
	input  wire logic [1:0]  s_tuser,  // req_type[1:0]
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [7:0]  m_tdata,  // outcome[1:0], zero fill
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	localparam int LW   = $clog2(MAX_ADAPTER_LEN);
	localparam int CW   = $clog2(MAX_ADAPTER_LEN + 1);
	localparam int AIW  = (MAX_ADAPTERS > 1) ? $clog2(MAX_ADAPTERS) : 1;
	localparam int ACW  = $clog2(MAX_ADAPTERS + 1);
	localparam int AAW  = AIW + LW;
	localparam int RAW  = $clog2(MAX_READ_LEN);
	localparam int RFW  = $clog2(MAX_READ_LEN + 1);
	localparam int EW   = CW + RFW + 8;
	localparam int N    = MAX_ADAPTER_LEN;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ADP  = 3'd1;
	localparam logic [2:0] ST_LOAD = 3'd2;
	localparam logic [2:0] ST_RUN  = 3'd3;
	localparam logic [2:0] ST_EVAL = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]     state_q;
	logic [5:0]     min_overlap_q;
	logic [6:0]     match_percent_q;
	logic [7:0]     quality_floor_q;
	logic [ACW-1:0] count_q;
	logic [CW-1:0]  fill_q;
	logic [CW-1:0]  lengths_q [MAX_ADAPTERS];
	logic [RFW-1:0] rfill_q;
	logic [RFW-1:0] rlen_q;
	logic [ACW-1:0] a_q;
	logic [CW-1:0]  alen_q;
	logic [CW-1:0]  cnt_q;
	logic           v_s1;
	logic [1:0]     res_q;
	logic [1:0]     outcome_q;
	logic           m_tvalid_q;

	logic            s_acc;
	logic            cfg_wr;
	logic            adp_we;
	logic [AAW-1:0]  adp_addr;
	logic [7:0]      adp_rdata;
	logic            rd_we;
	logic [RAW-1:0]  rd_addr;
	logic [15:0]     rd_rdata;
	logic            issue;
	logic [CW-1:0]  cur_len;
	logic [CW-1:0]  fill_inc;
	logic [CW-1:0]  j;
	logic           d_ok;
	logic           hit;
	logic [EW-1:0]  lhs;
	logic [EW-1:0]  rhs;

	apom_pkg::cell_ctl_t ctl;
	logic [N-1:0]        c_vld;
	logic [7:0]          c_base  [N];
	logic [CW-1:0]       c_score [N];

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, outcome_q};

	always_comb begin
		unique case (paddr[3:2])
			apom_pkg::REG_MIN_OVERLAP:   prdata = {26'd0, min_overlap_q};
			apom_pkg::REG_MATCH_PERCENT: prdata = {25'd0, match_percent_q};
			apom_pkg::REG_QUALITY_FLOOR: prdata = {24'd0, quality_floor_q};
			default:                     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_overlap_q   <= apom_pkg::MIN_OVERLAP_RST;
			match_percent_q <= apom_pkg::MATCH_PERCENT_RST;
			quality_floor_q <= apom_pkg::QUALITY_FLOOR_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				apom_pkg::REG_MIN_OVERLAP:   min_overlap_q   <= pwdata[5:0];
				apom_pkg::REG_MATCH_PERCENT: match_percent_q <= pwdata[6:0];
				apom_pkg::REG_QUALITY_FLOOR: quality_floor_q <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// memories
	assign fill_inc = fill_q + ((fill_q < CW'(MAX_ADAPTER_LEN)) ? CW'(1) : CW'(0));
	assign adp_we   = s_acc && (s_tuser == apom_pkg::REQ_ADAPTER) &&
			(count_q < ACW'(MAX_ADAPTERS)) && (fill_q < CW'(MAX_ADAPTER_LEN));
	assign rd_we    = s_acc && (s_tuser == apom_pkg::REQ_READ) &&
			(rfill_q < RFW'(MAX_READ_LEN));
	assign issue    = ((state_q == ST_LOAD) || (state_q == ST_RUN)) && (cnt_q < alen_q);

	always_comb begin
		if (state_q == ST_IDLE) begin
			adp_addr = {count_q[AIW-1:0], fill_q[LW-1:0]};
			rd_addr  = rfill_q[RAW-1:0];
		end else begin
			cur_len  = alen_q - CW'(1) - cnt_q;
			adp_addr = {a_q[AIW-1:0], cur_len[LW-1:0]};
			rd_addr  = RAW'(cnt_q);
		end
		cur_len = alen_q - CW'(1) - cnt_q;
	end

	apom_ram #(.W(8), .D(1 << AAW)) u_adp_ram (
		.clk   (clk),
		.we    (adp_we),
		.addr  (adp_addr),
		.wdata (s_tdata[7:0]),
		.rdata (adp_rdata)
	);

	apom_ram #(.W(16), .D(1 << RAW)) u_rd_ram (
		.clk   (clk),
		.we    (rd_we),
		.addr  (rd_addr),
		.wdata (s_tdata),
		.rdata (rd_rdata)
	);

	// cell row control
	always_comb begin
		ctl.rbase = rd_rdata[7:0];
		ctl.qlow  = rd_rdata[15:8] < quality_floor_q;
		ctl.op    = apom_pkg::CELL_HOLD;
		unique case (state_q)
			ST_ADP:  ctl.op = apom_pkg::CELL_CLEAR;
			ST_LOAD: ctl.op = v_s1 ? apom_pkg::CELL_LOAD : apom_pkg::CELL_HOLD;
			ST_RUN:  ctl.op = v_s1 ? apom_pkg::CELL_RUN : apom_pkg::CELL_HOLD;
			ST_EVAL: ctl.op = apom_pkg::CELL_EVAL;
			default: ctl.op = apom_pkg::CELL_HOLD;
		endcase
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic          up_vld;
		logic [7:0]    up_base;
		logic          dn_vld;
		logic [7:0]    dn_base;
		logic [CW-1:0] dn_score;
		if (i == 0) begin : g_first
			assign up_vld  = 1'b1;
			assign up_base = adp_rdata;
		end else begin : g_mid
			assign up_vld  = c_vld[i-1];
			assign up_base = c_base[i-1];
		end
		if (i == N - 1) begin : g_last
			assign dn_vld   = 1'b0;
			assign dn_base  = '0;
			assign dn_score = '0;
		end else begin : g_inner
			assign dn_vld   = c_vld[i+1];
			assign dn_base  = c_base[i+1];
			assign dn_score = c_score[i+1];
		end
		apom_cell #(.SW(CW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.up_vld   (up_vld),
			.up_base  (up_base),
			.dn_vld   (dn_vld),
			.dn_base  (dn_base),
			.dn_score (dn_score),
			.vld_q    (c_vld[i]),
			.base_q   (c_base[i]),
			.score_q  (c_score[i])
		);
	end

	// score check for the offset at the head of the row
	assign j    = alen_q - cnt_q;
	assign d_ok = (cnt_q != '0) && (EW'(j) > EW'(min_overlap_q)) && (EW'(j) < EW'(rlen_q));
	assign lhs  = EW'(c_score[0]) * EW'(apom_pkg::PERCENT_SCALE);
	assign rhs  = EW'(8'(match_percent_q) + 8'd1) * EW'(j);
	assign hit  = d_ok && (lhs >= rhs);

	always_ff @(posedge clk) begin
		if (s_acc && (s_tuser == apom_pkg::REQ_ADAPTER) && s_tlast &&
				(count_q < ACW'(MAX_ADAPTERS))) begin
			lengths_q[count_q[AIW-1:0]] <= fill_inc;
		end
		if (state_q == ST_ADP) begin
			alen_q <= lengths_q[a_q[AIW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			fill_q     <= '0;
			rfill_q    <= '0;
			rlen_q     <= '0;
			a_q        <= '0;
			cnt_q      <= '0;
			v_s1       <= 1'b0;
			res_q      <= apom_pkg::OUT_NO_MATCH;
			outcome_q  <= apom_pkg::OUT_NO_MATCH;
			m_tvalid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			v_s1 <= issue;
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						unique case (s_tuser)
							apom_pkg::REQ_CLEAR: begin
								count_q <= '0;
								fill_q  <= '0;
							end
							apom_pkg::REQ_ADAPTER: begin
								if (count_q < ACW'(MAX_ADAPTERS)) begin
									if (s_tlast) begin
										count_q <= count_q + ACW'(1);
										fill_q  <= '0;
									end else begin
										fill_q <= fill_inc;
									end
								end else if (s_tlast) begin
									fill_q <= '0;
								end
							end
							apom_pkg::REQ_READ: begin
								if (s_tlast) begin
									rlen_q  <= rfill_q + (rd_we ? RFW'(1) : RFW'(0));
									rfill_q <= '0;
									a_q     <= '0;
									state_q <= ST_ADP;
								end else if (rd_we) begin
									rfill_q <= rfill_q + RFW'(1);
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_ADP: begin
					cnt_q <= '0;
					if (a_q >= count_q) begin
						res_q   <= apom_pkg::OUT_NO_MATCH;
						state_q <= ST_DONE;
					end else if (EW'(lengths_q[a_q[AIW-1:0]]) <= EW'(min_overlap_q)) begin
						res_q   <= apom_pkg::OUT_INVALID;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD, ST_RUN: begin
					if (issue) begin
						cnt_q <= cnt_q + CW'(1);
					end else if (!v_s1) begin
						cnt_q   <= '0;
						state_q <= (state_q == ST_LOAD) ? ST_RUN : ST_EVAL;
					end
				end
				ST_EVAL: begin
					cnt_q <= cnt_q + CW'(1);
					if (hit) begin
						res_q   <= apom_pkg::OUT_MATCH;
						state_q <= ST_DONE;
					end else if (cnt_q == alen_q - CW'(1)) begin
						a_q     <= a_q + ACW'(1);
						state_q <= ST_ADP;
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						outcome_q <= res_q;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/apom_ram.sv -----
// generic single-port ram with registered read
// no dependencies
`default_nettype none
module apom_ram #(
	parameter int W = 8,
	parameter int D = 256
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] addr,
	input  wire logic [W-1:0]         wdata,
	output logic      [W-1:0]         rdata
);

	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule
`default_nettype wire

// ----- hw/rtl/apom_cell.sv -----
// one overlap cell: holds an adapter base and the score of one offset
// depends on apom_pkg
`default_nettype none
module apom_cell #(
	parameter int SW = 7
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire apom_pkg::cell_ctl_t ctl,
	input  wire logic                up_vld,
	input  wire logic [7:0]          up_base,
	input  wire logic                dn_vld,
	input  wire logic [7:0]          dn_base,
	input  wire logic [SW-1:0]       dn_score,
	output logic                     vld_q,
	output logic      [7:0]          base_q,
	output logic      [SW-1:0]       score_q
);

	logic hit;

	assign hit = vld_q && ((base_q == ctl.rbase) || ctl.qlow);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			unique case (ctl.op)
				apom_pkg::CELL_CLEAR: vld_q <= 1'b0;
				apom_pkg::CELL_LOAD:  vld_q <= up_vld;
				apom_pkg::CELL_RUN:   vld_q <= dn_vld;
				default:              vld_q <= vld_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			apom_pkg::CELL_CLEAR: begin
				score_q <= '0;
			end
			apom_pkg::CELL_LOAD: begin
				base_q <= up_base;
			end
			apom_pkg::CELL_RUN: begin
				base_q <= dn_base;
				if (hit) begin
					score_q <= score_q + SW'(1);
				end
			end
			apom_pkg::CELL_EVAL: begin
				score_q <= dn_score;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- bench/apom_checker.sv -----
// checker for the adapter prefix overlap matcher: watches both streams and the apb port
// keeps its own adapter table and read buffer and predicts each outcome; depends on apom_pkg
`timescale 1ns / 100ps
`default_nettype none
module apom_checker (
	input  wire logic        clk,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [15:0] s_tdata,
	input  wire logic [1:0]  s_tuser,
	input  wire logic        s_tlast,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [7:0]  m_tdata,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output int               errors,
	output int               pending,
	output int               outcomes_seen
);
	import apom_pkg::*;

	localparam int NA = MAX_ADAPTERS_DEF;
	localparam int LA = MAX_ADAPTER_LEN_DEF;
	localparam int LR = MAX_READ_LEN_DEF;

	logic [7:0] ad_base [NA*LA];
	int         ad_len [NA];
	int         ad_cnt, ad_fill;
	logic [7:0] rd_base [LR];
	logic [7:0] rd_qual [LR];
	int         rd_fill;
	int         min_ovl, pct, qfloor;
	logic [1:0] outcome_q[$];

	initial begin
		errors = 0;
		outcomes_seen = 0;
		ad_cnt = 0;
		ad_fill = 0;
		rd_fill = 0;
		min_ovl = MIN_OVERLAP_RST;
		pct = MATCH_PERCENT_RST;
		qfloor = QUALITY_FLOOR_RST;
	end

	assign pending = outcome_q.size();

	function automatic logic [1:0] judge_overlap();
		int score;
		int alen, lim;
		for (int a = 0; a < ad_cnt; a++) begin
			alen = ad_len[a];
			if (alen <= min_ovl)
				return OUT_INVALID;
			lim = (alen < rd_fill) ? alen : rd_fill;
			for (int j = min_ovl + 1; j < lim; j++) begin
				score = 0;
				for (int k = 0; k < j; k++)
					if (rd_base[k] == ad_base[a*LA + alen - j + k] || rd_qual[k] < qfloor)
						score++;
				if ((PERCENT_SCALE * score) / j > pct)
					return OUT_MATCH;
			end
		end
		return OUT_NO_MATCH;
	endfunction

	always @(posedge clk) begin
		logic [1:0] exp_o;
		if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_MIN_OVERLAP:   min_ovl = pwdata[5:0];
				REG_MATCH_PERCENT: pct = pwdata[6:0];
				REG_QUALITY_FLOOR: qfloor = pwdata[7:0];
				default: ;
			endcase
		end
		if (s_tvalid && s_tready) begin
			case (s_tuser)
				REQ_CLEAR: begin
					ad_cnt = 0;
					ad_fill = 0;
				end
				REQ_ADAPTER: begin
					if (ad_cnt < NA) begin
						if (ad_fill < LA) begin
							ad_base[ad_cnt*LA + ad_fill] = s_tdata[7:0];
							ad_fill++;
						end
						if (s_tlast) begin
							ad_len[ad_cnt] = ad_fill;
							ad_cnt++;
							ad_fill = 0;
						end
					end else if (s_tlast)
						ad_fill = 0;
				end
				REQ_READ: begin
					if (rd_fill < LR) begin
						rd_base[rd_fill] = s_tdata[7:0];
						rd_qual[rd_fill] = s_tdata[15:8];
						rd_fill++;
					end
					if (s_tlast) begin
						outcome_q.push_back(judge_overlap());
						rd_fill = 0;
					end
				end
				default: ;
			endcase
		end
		if (m_tvalid && m_tready) begin
			outcomes_seen++;
			if (outcome_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected outcome %0d at %0t", m_tdata[1:0], $realtime);
			end else begin
				exp_o = outcome_q.pop_front();
				if (m_tdata !== {6'd0, exp_o}) begin
					errors++;
					if (errors <= 10)
						$display("outcome mismatch: expected %0d got %0d at %0t",
							exp_o, m_tdata, $realtime);
				end
			end
		end
	end
endmodule
`default_nettype wire

// ----- bench/adapter_prefix_overlap_matcher_top_tb.sv -----
// testbench top for adapter_prefix_overlap_matcher_top: clock, reset, apb writes, stimulus
// builds adapter tables and reads, drives random gaps and stalls; depends on it, apom_pkg, apom_checker
`timescale 1ns / 100ps
`default_nettype none
module adapter_prefix_overlap_matcher_top_tb;
	import apom_pkg::*;

	logic        clk, arst_n;
	logic        s_tvalid, s_tready, s_tlast;
	logic [15:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid, m_tready;
	logic [7:0]  m_tdata;
	logic        psel, penable, pwrite, pready;
	logic [3:0]  paddr;
	logic [31:0] pwdata, prdata;
	int          errors, pending, outcomes_seen;
	int          items_sent, idle_cycles;
	bit          calm, hold_rx;
	int          hold_len;

	adapter_prefix_overlap_matcher_top u_dut (.*);

	apom_checker u_chk (.clk, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
		.m_tvalid, .m_tready, .m_tdata, .psel, .penable, .pwrite, .paddr, .pwdata,
		.errors, .pending, .outcomes_seen);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		m_tready = 0;
		forever begin
			@(negedge clk);
			if (hold_rx && hold_len > 0) begin
				m_tready <= 0;
				hold_len--;
			end else
				m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 21);
		end
	end

	// watchdog on cycles without any transaction
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
				idle_cycles = 0;
			else if (++idle_cycles > 20000) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	task automatic reg_write(input logic [1:0] idx, input int val);
		@(negedge clk);
		psel <= 1;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic send_item(input logic [1:0] req, input logic [7:0] sym,
		input logic [7:0] qual, input bit lst);
		while (!calm && $urandom_range(99) < 21) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= req;
		s_tdata <= {qual, sym};
		s_tlast <= lst;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (pending != 0)
			@(negedge clk);
		repeat (3000) @(negedge clk);
	endtask

	function automatic logic [7:0] rand_base();
		case ($urandom_range(4))
			0: return "A";
			1: return "C";
			2: return "G";
			3: return "T";
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic load_adapter(input int len, inout logic [7:0] seq[$]);
		seq = {};
		for (int i = 0; i < len; i++) begin
			seq.push_back(rand_base());
			send_item(REQ_ADAPTER, seq[i], 8'($urandom_range(255)), i == len - 1);
		end
	endtask

	// read whose head copies an adapter tail of random length, with some mutation
	task automatic send_read(input int len, input logic [7:0] tail_src[$]);
		int ov;
		logic [7:0] b;
		ov = (tail_src.size() > 1) ? $urandom_range(tail_src.size() - 1) : 0;
		for (int i = 0; i < len; i++) begin
			b = (i < ov && $urandom_range(9) != 0) ?
				tail_src[tail_src.size() - ov + i] : rand_base();
			send_item(REQ_READ, b, 8'($urandom_range(255)), i == len - 1);
		end
	endtask

	initial begin
		logic [7:0] seq[$];
		logic [7:0] none[$];
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = 0;
		s_tuser = 0;
		s_tlast = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		calm = 0;
		hold_rx = 0;
		hold_len = 0;
		items_sent = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: no adapters, odd request, extremes of the fields
		send_item(REQ_READ, 8'h00, 8'h00, 0);
		send_item(REQ_READ, 8'hff, 8'hff, 1);
		send_item(2'd3, 8'hff, 8'hff, 1);
		load_adapter(12, seq);
		send_read(12, seq);
		send_item(REQ_READ, 8'hA5, 8'h5A, 1);
		load_adapter(4, seq);
		send_read(10, seq);
		send_item(REQ_CLEAR, 8'hff, 8'hff, 1);
		load_adapter(70, seq);
		send_read(20, seq);
		drain();
		reg_write(REG_MATCH_PERCENT, 127);
		reg_write(REG_MIN_OVERLAP, 63);
		reg_write(REG_QUALITY_FLOOR, 255);
		send_read(5, seq);
		drain();
		reg_write(REG_MIN_OVERLAP, 0);
		reg_write(REG_MATCH_PERCENT, 0);
		reg_write(REG_QUALITY_FLOOR, 0);
		send_item(REQ_CLEAR, 8'h00, 8'h00, 0);
		load_adapter(3, seq);
		send_read(4, seq);
		send_item(REQ_READ, 8'h41, 8'h00, 1);
		drain();

		// random phases with varying settings
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin reg_write(REG_MIN_OVERLAP, 8); reg_write(REG_MATCH_PERCENT, 80);
					reg_write(REG_QUALITY_FLOOR, 48); end
				1: begin reg_write(REG_MIN_OVERLAP, 2); reg_write(REG_MATCH_PERCENT, 100);
					reg_write(REG_QUALITY_FLOOR, 0); end
				default: begin
					reg_write(REG_MIN_OVERLAP, $urandom_range(10));
					reg_write(REG_MATCH_PERCENT, $urandom_range(127));
					reg_write(REG_QUALITY_FLOOR, $urandom_range(255));
				end
			endcase
			calm = (ph == 3);
			send_item(REQ_CLEAR, 8'($urandom_range(255)), 8'($urandom_range(255)),
				1'($urandom_range(1)));
			for (int a = 0, n = $urandom_range(1, (ph == 5) ? 18 : 4); a < n; a++)
				load_adapter((ph == 6 && a == 0) ? 66 : $urandom_range(6, 20), seq);
			if (ph == 4) begin
				hold_len = 400;
				hold_rx = 1;
			end
			while (items_sent < 150 + ph * 160) begin
				case ($urandom_range(19))
					0: send_item(2'd3, 8'($urandom_range(255)), 8'($urandom_range(255)),
						1'($urandom_range(1)));
					1: send_read($urandom_range(1, 3), none);
					2: send_read((ph == 7) ? 270 : 30, seq);
					default: send_read($urandom_range(6, 24), seq);
				endcase
			end
			hold_rx = 0;
			calm = 0;
			drain();
		end

		$display("sent %0d input transactions, checked %0d outcomes across 11 register settings",
			items_sent, outcomes_seen);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
`default_nettype wire
